>>> hdl/tapc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tapc_pkg
// Shared types and constants of the tilemap area passability check.
// ----------------------------------------------------------------------------
package tapc_pkg;

  localparam int TilePixels = 32;
  localparam int TileShift  = $clog2(TilePixels);
  localparam int MaxTiles   = 65536;
  localparam int AddrW      = $clog2(MaxTiles);
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 16;

  localparam logic [CfgIdxW-1:0] CfgOriginX = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgOriginY = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgTilesX  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgTilesY  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgChunksX = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgChunksY = 3'd5;

  localparam logic CmdWrite = 1'b0;
  localparam logic CmdQuery = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [3:0]         chunk_index;
    logic [11:0]        tile_index;
    logic               tile_passable;
    logic signed [15:0] query_x;
    logic signed [15:0] query_y;
    logic [11:0]        query_w;
    logic [11:0]        query_h;
  } in_word_t;

  typedef struct packed {
    logic area_free;
    logic outside_map;
  } out_word_t;

  typedef enum logic [2:0] {
    StIdle,
    StBounds,
    StDivX,
    StDivY,
    StInit,
    StRead,
    StCheck,
    StDone
  } state_e;

endpackage

>>> hdl/tilemap_area_passability_check_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilemap_area_passability_check_core
// Tile flag store with rectangle passability queries over a chunked map.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i / in_ready_o | in_word_i (tapc_pkg::in_word_t)
// out     | output    | out_valid_o/out_ready_i | out_word_o (tapc_pkg::out_word_t)
// cfg     | input     | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// A query runs the bound check, the shared restoring divider for x and then
// for y, a setup state, a read and a check state per covered tile on the
// flag memory's registered read port, and a final state that loads the
// output register; a query with a corner outside the map goes to that final
// state right after the bound check. The block is not ready while a query
// runs. Reset clears control and configuration; the flag memory is not
// cleared. A result waiting on out_ready_i holds the sequencer in its final
// state, and no word is taken until the output register frees up.
// ----------------------------------------------------------------------------
module tilemap_area_passability_check_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tapc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tapc_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  tapc_pkg::in_word_t            in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output tapc_pkg::out_word_t           out_word_o
);
  import tapc_pkg::*;

  logic signed [15:0] org_x_q, org_y_q;
  logic [6:0]         tpc_x_q, tpc_y_q;
  logic [2:0]         chk_x_q, chk_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q <= '0;
      org_y_q <= '0;
      tpc_x_q <= 7'd1;
      tpc_y_q <= 7'd1;
      chk_x_q <= 3'd1;
      chk_y_q <= 3'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgOriginX: org_x_q <= cfg_data_i;
        CfgOriginY: org_y_q <= cfg_data_i;
        CfgTilesX:  tpc_x_q <= cfg_data_i[6:0];
        CfgTilesY:  tpc_y_q <= cfg_data_i[6:0];
        CfgChunksX: chk_x_q <= cfg_data_i[2:0];
        CfgChunksY: chk_y_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // Sizes saturated into their legal ranges.
  logic [6:0] txc, tyc;
  logic [2:0] cac, cdc;
  always_comb begin
    txc = (tpc_x_q == 7'd0) ? 7'd1 : ((tpc_x_q > 7'd64) ? 7'd64 : tpc_x_q);
    tyc = (tpc_y_q == 7'd0) ? 7'd1 : ((tpc_y_q > 7'd64) ? 7'd64 : tpc_y_q);
    cac = (chk_x_q == 3'd0) ? 3'd1 : ((chk_x_q > 3'd4) ? 3'd4 : chk_x_q);
    cdc = (chk_y_q == 3'd0) ? 3'd1 : ((chk_y_q > 3'd4) ? 3'd4 : chk_y_q);
  end

  state_e    state_q, state_d;
  in_word_t  req_q, req_d;
  logic [7:0] gx_q, gx_d, gx0_q, gx0_d, gx1_q, gx1_d;
  logic [7:0] gy_q, gy_d, gy1_q, gy1_d;
  logic [5:0] rx_q, rx_d, rx0_q, rx0_d, ry_q, ry_d;
  logic [1:0] cx_q, cx_d, cx0_q, cx0_d, cy_q, cy_d;
  logic [11:0] row_q, row_d;
  logic [3:0] cyb_q, cyb_d;
  logic [7:0] dvd_q, dvd_d, rem_q, rem_d;
  logic [2:0] cnt_q, cnt_d;
  logic       free_q, free_d, outs_q, outs_d;
  logic       out_valid_q, out_valid_d;
  out_word_t  out_word_q, out_word_d;
  logic       in_acc;

  // Bound check and tile coordinates of the captured query.
  logic [9:0]          span_x, span_y;
  logic signed [17:0]  dx0, dx1, dy0, dy1, lim_x, lim_y;
  logic                outside;
  assign span_x = 10'(txc * cac);
  assign span_y = 10'(tyc * cdc);
  assign dx0 = 18'(req_q.query_x) - 18'(org_x_q);
  assign dy0 = 18'(req_q.query_y) - 18'(org_y_q);
  assign dx1 = dx0 + $signed({6'd0, req_q.query_w});
  assign dy1 = dy0 + $signed({6'd0, req_q.query_h});
  assign lim_x = $signed(18'(span_x) << TileShift);
  assign lim_y = $signed(18'(span_y) << TileShift);
  assign outside = dx0[17] || dy0[17] || (dx1 >= lim_x) || (dy1 >= lim_y);

  // Shared restoring divider step: divisor is tiles across or tiles down.
  logic [6:0] div_by;
  logic [8:0] trial, diff;
  logic       qbit;
  logic [7:0] q_next, r_next;
  always_comb begin
    div_by = (state_q == StDivY) ? tyc : txc;
    trial  = {rem_q, dvd_q[7]};
    diff   = trial - {2'd0, div_by};
    qbit   = !diff[8];
    r_next = qbit ? diff[7:0] : trial[7:0];
    q_next = {dvd_q[6:0], qbit};
  end

  logic [AddrW-1:0] rd_addr;
  logic             flag_q;
  logic             tile_mem_q [MaxTiles];

  // Outputs of the sequencer.
  always_comb begin
    in_ready_o = (state_q == StIdle);
    rd_addr    = {4'(cx_q) + cyb_q, 12'(rx_q) + row_q};
  end
  assign in_acc = in_valid_i && in_ready_o;

  // Next state and datapath.
  always_comb begin
    state_d = state_q; req_d = req_q;
    gx_d = gx_q; gx0_d = gx0_q; gx1_d = gx1_q; gy_d = gy_q; gy1_d = gy1_q;
    rx_d = rx_q; rx0_d = rx0_q; ry_d = ry_q;
    cx_d = cx_q; cx0_d = cx0_q; cy_d = cy_q;
    row_d = row_q; cyb_d = cyb_q;
    dvd_d = dvd_q; rem_d = rem_q; cnt_d = cnt_q;
    free_d = free_q; outs_d = outs_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_word_d = out_word_q;
    unique case (state_q)
      StIdle: begin
        if (in_acc && in_word_i.cmd == CmdQuery) begin
          req_d   = in_word_i;
          state_d = StBounds;
        end
      end
      StBounds: begin
        gx0_d = dx0[TileShift +: 8]; gx1_d = dx1[TileShift +: 8];
        gy_d  = dy0[TileShift +: 8]; gy1_d = dy1[TileShift +: 8];
        gx_d  = dx0[TileShift +: 8];
        dvd_d = dx0[TileShift +: 8]; rem_d = '0; cnt_d = '0;
        if (outside) begin
          free_d = 1'b1; outs_d = 1'b1; state_d = StDone;
        end else begin
          outs_d = 1'b0; state_d = StDivX;
        end
      end
      StDivX: begin
        dvd_d = q_next; rem_d = r_next; cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          cx0_d = q_next[1:0]; rx0_d = r_next[5:0];
          cx_d  = q_next[1:0]; rx_d  = r_next[5:0];
          dvd_d = gy_q; rem_d = '0;
          state_d = StDivY;
        end
      end
      StDivY: begin
        dvd_d = q_next; rem_d = r_next; cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          cy_d = q_next[1:0]; ry_d = r_next[5:0];
          state_d = StInit;
        end
      end
      StInit: begin
        row_d = 12'(ry_q * txc);
        cyb_d = 4'(cy_q * cac);
        state_d = StRead;
      end
      StRead: state_d = StCheck;
      StCheck: begin
        state_d = StRead;
        if (!flag_q) begin
          free_d = 1'b0; state_d = StDone;
        end else if (gx_q == gx1_q) begin
          if (gy_q == gy1_q) begin
            free_d = 1'b1; state_d = StDone;
          end else begin
            gy_d = gy_q + 8'd1;
            gx_d = gx0_q; rx_d = rx0_q; cx_d = cx0_q;
            if (7'(ry_q) == tyc - 7'd1) begin
              ry_d = '0; row_d = '0; cy_d = cy_q + 2'd1;
              cyb_d = cyb_q + 4'(cac);
            end else begin
              ry_d = ry_q + 6'd1; row_d = row_q + 12'(txc);
            end
          end
        end else begin
          gx_d = gx_q + 8'd1;
          if (7'(rx_q) == txc - 7'd1) begin
            rx_d = '0; cx_d = cx_q + 2'd1;
          end else begin
            rx_d = rx_q + 6'd1;
          end
        end
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_word_d.area_free = free_q;
          out_word_d.outside_map = outs_q;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    gx_q <= gx_d; gx0_q <= gx0_d; gx1_q <= gx1_d; gy_q <= gy_d; gy1_q <= gy1_d;
    rx_q <= rx_d; rx0_q <= rx0_d; ry_q <= ry_d;
    cx_q <= cx_d; cx0_q <= cx0_d; cy_q <= cy_d;
    row_q <= row_d; cyb_q <= cyb_d;
    dvd_q <= dvd_d; rem_q <= rem_d; cnt_q <= cnt_d;
    free_q <= free_d; outs_q <= outs_d;
    out_word_q <= out_word_d;
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_word_i.cmd == CmdWrite) begin
      tile_mem_q[{in_word_i.chunk_index, in_word_i.tile_index}] <= in_word_i.tile_passable;
    end
    flag_q <= tile_mem_q[rd_addr];
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

`ifndef SYNTHESIS
  a_query_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_word_i.cmd == CmdQuery) |=> (state_q == StBounds))
    else $error("query word did not start the sequencer");
  a_write_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_word_i.cmd == CmdWrite) |=> (state_q == StIdle))
    else $error("write word left the idle state");
  a_outside_is_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.outside_map) |-> out_word_o.area_free)
    else $error("outside result not marked free");
  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone && !out_valid_q) |=> (out_valid_q && state_q == StIdle))
    else $error("finished query did not load the output register");
`endif

endmodule
